@@ hw/rtl/grt_pkg.sv @@
// constants and types shared by the glyph text renderer
`timescale 1ns / 1ps

package grt_pkg;

  // glyph geometry and framebuffer format
  localparam int GLYPH_WIDTH     = 8;
  localparam int GLYPH_HEIGHT    = 16;
  localparam int GLYPH_COUNT     = 256;
  localparam int PIXEL_BYTES     = 4;

  // derived widths
  localparam int ROW_W       = $clog2(GLYPH_HEIGHT);
  localparam int GLYPH_IDX_W = $clog2(GLYPH_COUNT);
  localparam int FONT_DEPTH  = GLYPH_COUNT * GLYPH_HEIGHT;
  localparam int FONT_ADDR_W = $clog2(FONT_DEPTH);
  localparam int PIX_SHIFT   = $clog2(PIXEL_BYTES);

  // widths of the fixed fields
  localparam int COLOR_W = 32;
  localparam int ADDR_W  = 32;
  localparam int COORD_W = 16;
  localparam int CODE_W  = 8;
  localparam int CFG_IDX_W = 3;

  // special character codes
  localparam logic [CODE_W-1:0] CODE_NEWLINE    = 8'h0A;
  localparam logic [CODE_W-1:0] CODE_UNDERSCORE = 8'h5F;

  // saturation limit of the character count
  localparam logic [COORD_W-1:0] COUNT_MAX = 16'hFFFF;

  // command codes
  typedef enum logic [1:0] {
    CMD_DRAW   = 2'd0,
    CMD_FINISH = 2'd1,
    CMD_HOME   = 2'd2,
    CMD_LOAD   = 2'd3
  } command_t;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FG_COLOR           = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLANK_COLOR        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CURSOR_FG_COLOR    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CURSOR_BLANK_COLOR = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_PITCH         = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_BASE         = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CURSOR_ENABLE      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CURSOR_POSITION    = 3'd7;

  // configuration reset values
  localparam logic [COLOR_W-1:0] FG_COLOR_RST           = 32'h00FF_FFFF;
  localparam logic [COLOR_W-1:0] BLANK_COLOR_RST        = 32'h0000_0000;
  localparam logic [COLOR_W-1:0] CURSOR_FG_COLOR_RST    = 32'h0000_0000;
  localparam logic [COLOR_W-1:0] CURSOR_BLANK_COLOR_RST = 32'h00FF_FFFF;
  localparam logic [COORD_W-1:0] LINE_PITCH_RST         = 16'd4096;
  localparam logic [ADDR_W-1:0]  FRAME_BASE_RST         = 32'h0000_0000;

endpackage

@@ hw/rtl/glyph_text_renderer.sv @@
// glyph text renderer: command decode, font memory and glyph row pipeline
// the first glyph row of a character passes the row sequencer, font read and output register
// a drawn character is its command transfer and 16 font reads, one per glyph row while not stalled;
// commands that draw nothing leave the input free; the next command is taken once the last row read is issued
// reset: cursor, character count, registers and pipeline valids return to defaults
// reset: font memory is not cleared and holds no data until loaded
`timescale 1ns / 1ps

module glyph_text_renderer import grt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  // configuration writes
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  // command channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           command,
  input  logic [CODE_W-1:0]    char_code,
  input  logic [3:0]           font_row,
  input  logic [7:0]           font_bits,
  // glyph row channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [ADDR_W-1:0]    row_address,
  output logic [COLOR_W-1:0]   pixel_0,
  output logic [COLOR_W-1:0]   pixel_1,
  output logic [COLOR_W-1:0]   pixel_2,
  output logic [COLOR_W-1:0]   pixel_3,
  output logic [COLOR_W-1:0]   pixel_4,
  output logic [COLOR_W-1:0]   pixel_5,
  output logic [COLOR_W-1:0]   pixel_6,
  output logic [COLOR_W-1:0]   pixel_7,
  output logic                 last_row
);

  // font memory address of one glyph row
  function automatic logic [FONT_ADDR_W-1:0] font_addr(
    input logic [GLYPH_IDX_W-1:0] glyph,
    input logic [FONT_ADDR_W-1:0] row
  );
    font_addr = FONT_ADDR_W'(glyph) * FONT_ADDR_W'(GLYPH_HEIGHT) + row;
  endfunction

  // configuration registers
  logic [COLOR_W-1:0] fg_color;
  logic [COLOR_W-1:0] blank_color;
  logic [COLOR_W-1:0] cursor_fg_color;
  logic [COLOR_W-1:0] cursor_blank_color;
  logic [COORD_W-1:0] line_pitch;
  logic [ADDR_W-1:0]  frame_base;
  logic               cursor_enable;
  logic [COORD_W-1:0] cursor_position;

  // text state
  logic [COORD_W-1:0] cursor_x;
  logic [COORD_W-1:0] cursor_y;
  logic [COORD_W-1:0] char_count;

  // row sequencer
  logic                   busy;
  logic [ROW_W-1:0]       iss_row;
  logic [GLYPH_IDX_W-1:0] draw_glyph;
  logic [COORD_W-1:0]     draw_x;
  logic [COORD_W-1:0]     draw_y;
  logic                   draw_cur;

  // read stage
  logic               s1_vld;
  logic [COORD_W-1:0] s1_x;
  logic [COORD_W-1:0] s1_y;
  logic               s1_cur;
  logic               s1_last;
  logic [7:0]         font_q;

  // font memory
  logic [7:0] font_mem [FONT_DEPTH];

  logic                   in_xfer;
  logic                   cursor_hit;
  logic                   start_draw;
  logic                   mem_we;
  logic [FONT_ADDR_W-1:0] wr_addr;
  logic [FONT_ADDR_W-1:0] rd_addr;
  logic                   s1_adv;
  logic                   issue;
  logic                   iss_last;
  logic [ADDR_W-1:0]      row_prod;
  logic [COLOR_W-1:0]     sel_fg;
  logic [COLOR_W-1:0]     sel_bg;
  logic [COLOR_W-1:0]     pix [GLYPH_WIDTH];

  // command decode
  assign in_stall   = busy;
  assign in_xfer    = in_valid && !in_stall;
  assign cursor_hit = cursor_enable && (char_count == cursor_position);

  always_comb begin
    start_draw = 1'b0;
    mem_we     = 1'b0;
    case (command_t'(command))
      CMD_DRAW:   start_draw = in_xfer && (char_code != CODE_NEWLINE);
      CMD_FINISH: start_draw = in_xfer && cursor_hit;
      CMD_LOAD:   mem_we = in_xfer && (32'(char_code) < GLYPH_COUNT)
                         && (32'(font_row) < GLYPH_HEIGHT);
      default:    start_draw = 1'b0;
    endcase
  end

  assign wr_addr = font_addr(char_code[GLYPH_IDX_W-1:0], FONT_ADDR_W'(font_row));

  // pipeline control
  assign s1_adv   = s1_vld && (!out_valid || !out_stall);
  assign issue    = busy && (!s1_vld || s1_adv);
  assign iss_last = (iss_row == ROW_W'(GLYPH_HEIGHT - 1));
  assign rd_addr  = font_addr(draw_glyph, FONT_ADDR_W'(iss_row));

  // font memory write and registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      font_mem[wr_addr] <= font_bits;
    end
    if (issue) begin
      font_q <= font_mem[rd_addr];
    end
  end

  // configuration register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      fg_color           <= FG_COLOR_RST;
      blank_color        <= BLANK_COLOR_RST;
      cursor_fg_color    <= CURSOR_FG_COLOR_RST;
      cursor_blank_color <= CURSOR_BLANK_COLOR_RST;
      line_pitch         <= LINE_PITCH_RST;
      frame_base         <= FRAME_BASE_RST;
      cursor_enable      <= 1'b0;
      cursor_position    <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FG_COLOR:           fg_color           <= cfg_data;
        REG_BLANK_COLOR:        blank_color        <= cfg_data;
        REG_CURSOR_FG_COLOR:    cursor_fg_color    <= cfg_data;
        REG_CURSOR_BLANK_COLOR: cursor_blank_color <= cfg_data;
        REG_LINE_PITCH:         line_pitch         <= cfg_data[COORD_W-1:0];
        REG_FRAME_BASE:         frame_base         <= cfg_data;
        REG_CURSOR_ENABLE:      cursor_enable      <= cfg_data[0];
        REG_CURSOR_POSITION:    cursor_position    <= cfg_data[COORD_W-1:0];
        default:                cursor_enable      <= cursor_enable;
      endcase
    end
  end

  // cursor and character count updates
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x   <= '0;
      cursor_y   <= '0;
      char_count <= '0;
    end else if (in_xfer) begin
      case (command_t'(command))
        CMD_DRAW: begin
          if (char_code == CODE_NEWLINE) begin
            cursor_x <= '0;
            cursor_y <= cursor_y + COORD_W'(GLYPH_HEIGHT);
          end else begin
            cursor_x <= cursor_x + COORD_W'(GLYPH_WIDTH);
          end
          if (char_count != COUNT_MAX) begin
            char_count <= char_count + 1'b1;
          end
        end
        CMD_FINISH: char_count <= '0;
        CMD_HOME: begin
          cursor_x <= '0;
          cursor_y <= '0;
        end
        default: char_count <= char_count;
      endcase
    end
  end

  // row sequencer: one font read per cycle while the read stage can move
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      iss_row <= '0;
    end else if (start_draw) begin
      busy    <= 1'b1;
      iss_row <= '0;
    end else if (issue) begin
      busy    <= !iss_last;
      iss_row <= iss_last ? '0 : iss_row + 1'b1;
    end
  end

  // per character context, held for the whole glyph
  always_ff @(posedge clk) begin
    if (start_draw) begin
      draw_x   <= cursor_x;
      draw_y   <= cursor_y;
      draw_cur <= cursor_hit;
      if (command_t'(command) == CMD_FINISH) begin
        draw_glyph <= CODE_UNDERSCORE[GLYPH_IDX_W-1:0];
      end else begin
        draw_glyph <= char_code[GLYPH_IDX_W-1:0];
      end
    end
  end

  // read stage, aligned with the font memory output
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (issue) begin
      s1_vld <= 1'b1;
    end else if (s1_adv) begin
      s1_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_x    <= draw_x;
      s1_y    <= draw_y + COORD_W'(iss_row);
      s1_cur  <= draw_cur;
      s1_last <= iss_last;
    end
  end

  // address and pixel colours of the row in the read stage
  assign row_prod = {{(ADDR_W-COORD_W){1'b0}}, s1_y}
                  * {{(ADDR_W-COORD_W){1'b0}}, line_pitch};
  assign sel_fg   = s1_cur ? cursor_fg_color : fg_color;
  assign sel_bg   = s1_cur ? cursor_blank_color : blank_color;

  always_comb begin
    for (int c = 0; c < GLYPH_WIDTH; c++) begin
      pix[c] = font_q[GLYPH_WIDTH-1-c] ? sel_fg : sel_bg;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      row_address <= frame_base + row_prod
                   + {{(ADDR_W-COORD_W-PIX_SHIFT){1'b0}}, s1_x, {PIX_SHIFT{1'b0}}};
      pixel_0  <= pix[0];
      pixel_1  <= pix[1];
      pixel_2  <= pix[2];
      pixel_3  <= pix[3];
      pixel_4  <= pix[4];
      pixel_5  <= pix[5];
      pixel_6  <= pix[6];
      pixel_7  <= pix[7];
      last_row <= s1_last;
    end
  end

  // sequencer rests at row zero when idle
  a_idle_row_zero: assert property (@(posedge clk) disable iff (rst)
    !busy |-> (iss_row == '0))
    else $error("row counter not at zero while idle");

  // rows of a glyph are read in order without gaps
  a_row_step: assert property (@(posedge clk) disable iff (rst)
    (issue && !iss_last) |=> (busy && (iss_row == $past(iss_row) + 1'b1)))
    else $error("glyph row sequence broken");

  // reading the last row ends the glyph
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (issue && iss_last) |=> (!busy && s1_vld && s1_last))
    else $error("glyph did not end after last row");

  // a stalled output is never overwritten by the read stage
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !s1_adv)
    else $error("output register overwritten while stalled");

endmodule

@@ sim/tb_glyph_text_renderer.sv @@
// testbench for the glyph text renderer: directed and random command streams checked row by row
`timescale 1ns / 1ps
module tb_glyph_text_renderer;
  import grt_pkg::*;

  // one expected glyph row transfer
  typedef struct packed {
    logic [ADDR_W-1:0]       addr;
    logic [7:0][COLOR_W-1:0] pix;
    logic                    last;
  } glyph_row_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic [1:0]           command;
  logic [CODE_W-1:0]    char_code;
  logic [3:0]           font_row;
  logic [7:0]           font_bits;
  logic                 out_valid;
  logic                 out_stall;
  logic [ADDR_W-1:0]    row_address;
  logic [COLOR_W-1:0]   pixel_0, pixel_1, pixel_2, pixel_3;
  logic [COLOR_W-1:0]   pixel_4, pixel_5, pixel_6, pixel_7;
  logic                 last_row;

  glyph_text_renderer i_dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .command(command),
    .char_code(char_code), .font_row(font_row), .font_bits(font_bits),
    .out_valid(out_valid), .out_stall(out_stall), .row_address(row_address),
    .pixel_0(pixel_0), .pixel_1(pixel_1), .pixel_2(pixel_2), .pixel_3(pixel_3),
    .pixel_4(pixel_4), .pixel_5(pixel_5), .pixel_6(pixel_6), .pixel_7(pixel_7),
    .last_row(last_row)
  );

  // register shadows
  logic [COLOR_W-1:0] ink_fg, ink_bg, mark_fg, mark_bg;
  logic [COORD_W-1:0] pitch;
  logic [ADDR_W-1:0]  base;
  logic               mark_en;
  logic [COORD_W-1:0] mark_pos;

  // renderer state copy
  logic [COORD_W-1:0]      pen_x, pen_y, chars_seen;
  logic [7:0]              font_mem [GLYPH_COUNT][GLYPH_HEIGHT];
  logic [GLYPH_HEIGHT-1:0] row_loaded [GLYPH_COUNT];
  logic [CODE_W-1:0]       ready_codes [$];
  glyph_row_t              pending_rows [$];

  int mismatches;
  int items_sent;
  int stall_left;
  bit quiet;

  // clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  task automatic note_mismatch(input string what);
    if (mismatches < 40) $display("%0t ns: %s", $time, what);
    mismatches++;
  endtask

  // queue the rows of one glyph at the pen position
  task automatic queue_glyph_rows(input logic [CODE_W-1:0] code,
                                  input logic [COLOR_W-1:0] on_c,
                                  input logic [COLOR_W-1:0] off_c);
    glyph_row_t         r;
    logic [7:0]         bits;
    logic [COORD_W-1:0] y;
    for (int row = 0; row < GLYPH_HEIGHT; row++) begin
      bits = font_mem[code][row];
      y = pen_y + COORD_W'(row);
      r.addr = base + ADDR_W'(y) * ADDR_W'(pitch) + (ADDR_W'(pen_x) << PIX_SHIFT);
      for (int col = 0; col < GLYPH_WIDTH; col++) r.pix[col] = bits[7-col] ? on_c : off_c;
      r.last = (row == GLYPH_HEIGHT - 1);
      pending_rows.push_back(r);
    end
  endtask

  // state update and expected rows for one accepted command
  task automatic predict_command(input command_t op, input logic [CODE_W-1:0] code,
                                 input logic [3:0] row, input logic [7:0] bits);
    logic hit;
    hit = mark_en && (chars_seen == mark_pos);
    case (op)
      CMD_DRAW: begin
        if (code == CODE_NEWLINE) begin
          pen_x = '0;
          pen_y = pen_y + COORD_W'(GLYPH_HEIGHT);
        end else begin
          if (hit) queue_glyph_rows(code, mark_fg, mark_bg);
          else queue_glyph_rows(code, ink_fg, ink_bg);
          pen_x = pen_x + COORD_W'(GLYPH_WIDTH);
        end
        if (chars_seen != COUNT_MAX) chars_seen = chars_seen + 1'b1;
      end
      CMD_FINISH: begin
        if (hit) queue_glyph_rows(CODE_UNDERSCORE, mark_fg, mark_bg);
        chars_seen = '0;
      end
      CMD_HOME: begin
        pen_x = '0;
        pen_y = '0;
      end
      CMD_LOAD: begin
        font_mem[code][row] = bits;
        if (row_loaded[code] != '1) begin
          row_loaded[code][row] = 1'b1;
          if (row_loaded[code] == '1) ready_codes.push_back(code);
        end
      end
      default: ;
    endcase
  endtask

  // one command transfer, with an optional gap before it
  task automatic send_command(input command_t op, input logic [CODE_W-1:0] code,
                              input logic [3:0] row, input logic [7:0] bits);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    command   <= op;
    char_code <= code;
    font_row  <= row;
    font_bits <= bits;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_command(op, code, row, bits);
    items_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_FG_COLOR:           ink_fg = data;
      REG_BLANK_COLOR:        ink_bg = data;
      REG_CURSOR_FG_COLOR:    mark_fg = data;
      REG_CURSOR_BLANK_COLOR: mark_bg = data;
      REG_LINE_PITCH:         pitch = data[COORD_W-1:0];
      REG_FRAME_BASE:         base = data;
      REG_CURSOR_ENABLE:      mark_en = data[0];
      REG_CURSOR_POSITION:    mark_pos = data[COORD_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic program_registers(input logic [31:0] fg, bg, cfg, cbg,
                                   input logic [31:0] lp, fb, en, pos);
    write_reg(REG_FG_COLOR, fg);
    write_reg(REG_BLANK_COLOR, bg);
    write_reg(REG_CURSOR_FG_COLOR, cfg);
    write_reg(REG_CURSOR_BLANK_COLOR, cbg);
    write_reg(REG_LINE_PITCH, lp);
    write_reg(REG_FRAME_BASE, fb);
    write_reg(REG_CURSOR_ENABLE, en);
    write_reg(REG_CURSOR_POSITION, pos);
  endtask

  // drop valid, let every row drain, then cover the pipeline latency
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // a fully loaded glyph, or now and then a newline
  function automatic logic [CODE_W-1:0] pick_draw_code();
    if ($urandom_range(0, 5) == 0) return CODE_NEWLINE;
    return ready_codes[$urandom_range(0, ready_codes.size() - 1)];
  endfunction

  // fill every row of a set of glyphs before any draw reads them
  task automatic load_font_set();
    logic [CODE_W-1:0] codes [6] = '{8'h00, 8'hFF, CODE_UNDERSCORE, 8'h41, 8'hAA, 8'h80};
    logic [7:0] bits;
    foreach (codes[i]) begin
      for (int r = 0; r < GLYPH_HEIGHT; r++) begin
        if (codes[i] == 8'h00) bits = 8'h00;
        else if (codes[i] == 8'hFF) bits = 8'hFF;
        else if (codes[i] == 8'h80) bits = 8'h80;
        else bits = 8'($urandom);
        send_command(CMD_LOAD, codes[i], 4'(r), bits);
      end
    end
  endtask

  // draws with the register values left by reset
  task automatic test_default_config();
    send_command(CMD_DRAW, 8'h00, 4'($urandom), 8'($urandom));
    send_command(CMD_DRAW, 8'hFF, 4'($urandom), 8'($urandom));
    send_command(CMD_DRAW, CODE_NEWLINE, 4'($urandom), 8'($urandom));
    send_command(CMD_DRAW, 8'h41, 4'($urandom), 8'($urandom));
    send_command(CMD_FINISH, 8'($urandom), 4'($urandom), 8'($urandom));
    send_command(CMD_HOME, 8'($urandom), 4'($urandom), 8'($urandom));
    send_command(CMD_DRAW, 8'hAA, 4'($urandom), 8'($urandom));
  endtask

  // cursor colours mid string, newline counted, underscore at the end
  task automatic test_cursor_highlight();
    wait_idle();
    write_reg(REG_CURSOR_ENABLE, 32'd1);
    write_reg(REG_CURSOR_POSITION, 32'd2);
    send_command(CMD_FINISH, 8'($urandom), 4'($urandom), 8'($urandom));
    send_command(CMD_DRAW, 8'h41, 4'($urandom), 8'($urandom));
    send_command(CMD_DRAW, CODE_NEWLINE, 4'($urandom), 8'($urandom));
    send_command(CMD_DRAW, 8'hAA, 4'($urandom), 8'($urandom));
    send_command(CMD_DRAW, 8'hFF, 4'($urandom), 8'($urandom));
    send_command(CMD_FINISH, 8'($urandom), 4'($urandom), 8'($urandom));
    wait_idle();
    write_reg(REG_CURSOR_POSITION, 32'd3);
    send_command(CMD_DRAW, 8'h41, 4'($urandom), 8'($urandom));
    send_command(CMD_DRAW, 8'h00, 4'($urandom), 8'($urandom));
    send_command(CMD_DRAW, 8'h80, 4'($urandom), 8'($urandom));
    send_command(CMD_FINISH, 8'($urandom), 4'($urandom), 8'($urandom));
    wait_idle();
    write_reg(REG_CURSOR_POSITION, 32'd0);
    send_command(CMD_FINISH, 8'($urandom), 4'($urandom), 8'($urandom));
    send_command(CMD_HOME, 8'($urandom), 4'($urandom), 8'($urandom));
    send_command(CMD_DRAW, 8'hAA, 4'($urandom), 8'($urandom));
  endtask

  // address wrap at 32 bits, zero pitch, extreme colours
  task automatic test_address_extremes();
    wait_idle();
    program_registers(32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0,
                      32'hFFFF_FFFF, 32'hFFFF_FFFC, 32'h0, 32'h0);
    send_command(CMD_DRAW, CODE_NEWLINE, 4'($urandom), 8'($urandom));
    send_command(CMD_DRAW, 8'hFF, 4'($urandom), 8'($urandom));
    send_command(CMD_DRAW, 8'h80, 4'($urandom), 8'($urandom));
    wait_idle();
    program_registers(32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF,
                      32'hABCD_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0001_0001);
    send_command(CMD_DRAW, 8'h41, 4'($urandom), 8'($urandom));
    send_command(CMD_DRAW, 8'h00, 4'($urandom), 8'($urandom));
    send_command(CMD_FINISH, 8'($urandom), 4'($urandom), 8'($urandom));
  endtask

  // random strings under several register settings, the last phase without idling
  task automatic test_random_strings();
    int target;
    int len;
    int pick;
    for (int phase = 0; phase < 4; phase++) begin
      wait_idle();
      quiet = (phase == 3);
      case (phase)
        0: program_registers($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                             ($urandom & 32'hFFFF_FFFE) | 32'd1, $urandom_range(0, 6));
        1: program_registers(32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0,
                             32'h0000_FFFF, 32'hFFFF_FFFF, 32'd1, 32'd0);
        2: program_registers($urandom, $urandom, $urandom, $urandom, 32'h0, $urandom,
                             $urandom & 32'hFFFF_FFFE, $urandom);
        default: program_registers($urandom, $urandom, $urandom, $urandom, $urandom,
                                   $urandom, 32'd1, $urandom_range(0, 4));
      endcase
      target = items_sent + 35;
      while (items_sent < target) begin
        pick = $urandom_range(0, 9);
        if (pick <= 6) begin
          // a string, now and then left without its finish
          len = $urandom_range(0, 6);
          repeat (len) send_command(CMD_DRAW, pick_draw_code(), 4'($urandom), 8'($urandom));
          if ($urandom_range(0, 4) != 0)
            send_command(CMD_FINISH, 8'($urandom), 4'($urandom), 8'($urandom));
        end else if (pick == 7) begin
          send_command(CMD_HOME, 8'($urandom), 4'($urandom), 8'($urandom));
        end else begin
          send_command(CMD_LOAD, 8'($urandom), 4'($urandom), 8'($urandom));
        end
      end
    end
  endtask

  // receiver stall bursts
  always @(posedge clk) begin
    if (rst || quiet) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 4) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 3);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // compare each row transfer with the oldest expected row
  always @(posedge clk) begin : check_rows
    glyph_row_t              want;
    logic [7:0][COLOR_W-1:0] got;
    if (!rst && out_valid && !out_stall) begin
      got = {pixel_7, pixel_6, pixel_5, pixel_4, pixel_3, pixel_2, pixel_1, pixel_0};
      if (pending_rows.size() == 0) begin
        note_mismatch($sformatf("row transfer at %h with no row expected", row_address));
      end else begin
        want = pending_rows.pop_front();
        if (row_address !== want.addr)
          note_mismatch($sformatf("row_address got %h want %h", row_address, want.addr));
        for (int i = 0; i < GLYPH_WIDTH; i++)
          if (got[i] !== want.pix[i])
            note_mismatch($sformatf("pixel_%0d at %h got %h want %h",
                                    i, want.addr, got[i], want.pix[i]));
        if (last_row !== want.last)
          note_mismatch($sformatf("last_row at %h got %b want %b", want.addr, last_row, want.last));
      end
    end
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("glyph_text_renderer: mismatch");
    $finish;
  end

  // test sequence
  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    command = CMD_DRAW;
    char_code = '0;
    font_row = '0;
    font_bits = '0;
    quiet = 1'b0;
    mismatches = 0;
    items_sent = 0;
    ink_fg = FG_COLOR_RST;
    ink_bg = BLANK_COLOR_RST;
    mark_fg = CURSOR_FG_COLOR_RST;
    mark_bg = CURSOR_BLANK_COLOR_RST;
    pitch = LINE_PITCH_RST;
    base = FRAME_BASE_RST;
    mark_en = 1'b0;
    mark_pos = '0;
    pen_x = '0;
    pen_y = '0;
    chars_seen = '0;
    foreach (row_loaded[i]) row_loaded[i] = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    load_font_set();
    test_default_config();
    test_cursor_highlight();
    test_address_extremes();
    test_random_strings();
    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("glyph_text_renderer: match");
    end else begin
      $display("glyph_text_renderer: mismatch");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/grt_pkg.sv
hw/rtl/glyph_text_renderer.sv
sim/tb_glyph_text_renderer.sv
